// ===== design/scheme_literal_lexer_assert.svh =====
`ifndef SCHEME_LITERAL_LEXER_ASSERT_SVH
`define SCHEME_LITERAL_LEXER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SLX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SLX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/slx_pkg.sv =====
package slx_pkg;

	localparam int VALUE_BITS = 64;
	localparam int MAG_W      = VALUE_BITS - 1;
	localparam int PROD_W     = MAG_W + 4;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int OUT_DATA_W = ((VALUE_BITS + 3 + 7) / 8) * 8;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_F     = 8'h66;

	typedef enum logic [1:0] {
		KIND_INT,
		KIND_TRUE,
		KIND_FALSE,
		KIND_ERR
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_UNEXPECTED,
		ERR_UNDELIM,
		ERR_BOOL,
		ERR_OVERFLOW
	} err_t;

	typedef struct packed {
		kind_t                 kind;
		logic [VALUE_BITS-1:0] value;
		err_t                  err;
		logic                  last;
	} res_t;

	typedef struct packed {
		logic [1:0]     n;
		res_t [1:0]     r;
	} res_pair_t;

endpackage

// ===== design/slx_core.sv =====
`include "scheme_literal_lexer_assert.svh"

module slx_core
	import slx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_s1,
	input  logic       end_s1,
	output res_pair_t  pair
);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_COMMENT,
		MODE_MINUS,
		MODE_NUMBER,
		MODE_HASH,
		MODE_HALT
	} mode_t;

	mode_t            mode_q, mode_d;
	logic [MAG_W-1:0] acc_q, acc_d;
	logic             neg_q, neg_d;

	logic              is_digit, is_space, is_delim, do_idle;
	logic [3:0]        dig;
	logic [PROD_W-1:0] prod, acc_ext;
	logic [VALUE_BITS-1:0] mag_ext;
	res_pair_t         pair_c;

	function automatic res_t mk_res(kind_t kind, logic [VALUE_BITS-1:0] value, err_t err);
		res_t r;
		r.kind  = kind;
		r.value = value;
		r.err   = err;
		r.last  = 1'b0;
		return r;
	endfunction

	always_comb begin
		is_digit = (byte_s1 inside {[CH_ZERO:CH_NINE]}) && !end_s1;
		is_space = byte_s1 inside {CH_SPACE, [CH_TAB:CH_CR]};
		is_delim = end_s1 || is_space ||
			(byte_s1 inside {CH_LPAR, CH_RPAR, CH_SEMI, CH_QUOTE});
		dig      = 4'(byte_s1 - CH_ZERO);
		acc_ext  = PROD_W'(acc_q);
		prod     = (acc_ext << 3) + (acc_ext << 1) + PROD_W'(dig);
		mag_ext  = VALUE_BITS'(acc_q);
	end

	always_comb begin
		mode_d   = mode_q;
		acc_d    = acc_q;
		neg_d    = neg_q;
		do_idle  = 1'b0;
		pair_c   = '0;
		case (mode_q)
			MODE_IDLE: begin
				do_idle = 1'b1;
			end
			MODE_COMMENT: begin
				if (end_s1) begin
					pair_c.r[0] = mk_res(KIND_ERR, '0, ERR_UNEXPECTED);
					pair_c.n    = 2'd1;
					mode_d      = MODE_HALT;
				end else if (byte_s1 == CH_LF) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_MINUS: begin
				if (is_digit) begin
					acc_d  = MAG_W'(dig);
					neg_d  = 1'b1;
					mode_d = MODE_NUMBER;
				end else begin
					pair_c.r[0] = mk_res(KIND_ERR, '0, ERR_UNEXPECTED);
					pair_c.n    = 2'd1;
					mode_d      = MODE_HALT;
				end
			end
			MODE_NUMBER: begin
				if (is_digit) begin
					if (prod[PROD_W-1:MAG_W] != '0) begin
						pair_c.r[0] = mk_res(KIND_ERR, '0, ERR_OVERFLOW);
						pair_c.n    = 2'd1;
						mode_d      = MODE_HALT;
					end else begin
						acc_d = prod[MAG_W-1:0];
					end
				end else if (is_delim) begin
					pair_c.r[0] = mk_res(KIND_INT, neg_q ? (~mag_ext + 1'b1) : mag_ext,
						ERR_NONE);
					pair_c.n    = 2'd1;
					acc_d       = '0;
					neg_d       = 1'b0;
					mode_d      = MODE_IDLE;
					do_idle     = 1'b1;
				end else begin
					pair_c.r[0] = mk_res(KIND_ERR, '0, ERR_UNDELIM);
					pair_c.n    = 2'd1;
					mode_d      = MODE_HALT;
				end
			end
			MODE_HASH: begin
				if (!end_s1 && byte_s1 == CH_T) begin
					pair_c.r[0] = mk_res(KIND_TRUE, '0, ERR_NONE);
					pair_c.n    = 2'd1;
					mode_d      = MODE_IDLE;
				end else if (!end_s1 && byte_s1 == CH_F) begin
					pair_c.r[0] = mk_res(KIND_FALSE, '0, ERR_NONE);
					pair_c.n    = 2'd1;
					mode_d      = MODE_IDLE;
				end else begin
					pair_c.r[0] = mk_res(KIND_ERR, '0, ERR_BOOL);
					pair_c.n    = 2'd1;
					mode_d      = MODE_HALT;
				end
			end
			default: begin
				mode_d = MODE_HALT;
			end
		endcase

		if (do_idle) begin
			if (end_s1) begin
				pair_c.r[pair_c.n[0]] = mk_res(KIND_ERR, '0, ERR_UNEXPECTED);
				pair_c.n              = pair_c.n + 2'd1;
				mode_d                = MODE_HALT;
			end else if (is_space) begin
				mode_d = MODE_IDLE;
			end else if (byte_s1 == CH_SEMI) begin
				mode_d = MODE_COMMENT;
			end else if (is_digit) begin
				acc_d  = MAG_W'(dig);
				neg_d  = 1'b0;
				mode_d = MODE_NUMBER;
			end else if (byte_s1 == CH_DASH) begin
				mode_d = MODE_MINUS;
			end else if (byte_s1 == CH_HASH) begin
				mode_d = MODE_HASH;
			end else begin
				pair_c.r[pair_c.n[0]] = mk_res(KIND_ERR, '0, ERR_UNEXPECTED);
				pair_c.n              = pair_c.n + 2'd1;
				mode_d                = MODE_HALT;
			end
		end

		if (pair_c.n == 2'd2) begin
			pair_c.r[1].last = 1'b1;
		end else if (pair_c.n == 2'd1) begin
			pair_c.r[0].last = 1'b1;
		end

		pair = pair_c;
		if (!step) begin
			pair.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			neg_q  <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			neg_q  <= neg_d;
		end
	end

	`SLX_ASSERT_NEXT(a_halt_sticks, mode_q == MODE_HALT, mode_q == MODE_HALT,
		"lexer left halt without reset")
	`SLX_ASSERT_NOW(a_pair_starts_int, pair.n == 2'd2,
		pair.r[0].kind == KIND_INT && pair.r[1].kind == KIND_ERR,
		"two results not an integer followed by an error")
	`SLX_ASSERT_NOW(a_halt_silent, mode_q == MODE_HALT, pair.n == 2'd0,
		"result produced while halted")

endmodule

// ===== design/slx_res_fifo.sv =====
`include "scheme_literal_lexer_assert.svh"

module slx_res_fifo
	import slx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  res_pair_t push,
	output logic      room,
	output logic      head_valid,
	input  logic      head_pop,
	output res_t      head
);

	res_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q, free;
	logic             pop;

	assign free       = CNT_W'(FIFO_DEPTH) - count_q;
	assign room       = free >= CNT_W'(2);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_q];
	assign pop        = head_valid && head_pop;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r[0];
		end
		if (push.n == 2'd2) begin
			mem_q[PTR_W'(wr_q + 1'b1)] <= push.r[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= PTR_W'(wr_q + push.n);
			rd_q    <= PTR_W'(rd_q + pop);
			count_q <= CNT_W'(count_q + push.n - pop);
		end
	end

	`SLX_ASSERT_NOW(a_no_overrun, push.n != 2'd0, CNT_W'(push.n) <= free,
		"result queue overrun")
	`SLX_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(FIFO_DEPTH),
		"result queue count out of range")
	`SLX_ASSERT_NEXT(a_count_track, push.n == 2'd0 && !pop, $stable(count_q),
		"queue count moved without push or pop")

endmodule

// ===== design/scheme_literal_lexer.sv =====
// Flow: a beat accepted on the slave side is registered, then lexed and queued once the queue
// has room, and its first result is offered on the master side from the queue head.
// Throughput: one beat per cycle while the queue has room; a number closed by end of stream,
// a parenthesis or a quote yields two results, absorbed by a four-entry queue.
// Stall: a registered beat waits while the queue has fewer than two free entries.
// Reset: arst_n clears the lexer mode, accumulator, sign and queue pointers at once.
module scheme_literal_lexer
	import slx_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // byte_in
	input  logic                  s_axis_tlast,  // end_of_input
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // number_value, error_code, zero pad
	output logic [1:0]            m_axis_tuser,  // token_kind
	output logic                  m_axis_tlast   // last_of_run
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       room, advance;
	res_pair_t  pair;
	res_t       head;

	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	slx_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_s1 (byte_s1),
		.end_s1  (end_s1),
		.pair    (pair)
	);

	slx_res_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (pair),
		.room       (room),
		.head_valid (m_axis_tvalid),
		.head_pop   (m_axis_tready),
		.head       (head)
	);

	assign m_axis_tdata = OUT_DATA_W'({head.err, head.value});
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

endmodule
